// File: design/ffha_pkg.sv
package ffha_pkg;

    // Sizing of the heap and the tables
    localparam int HEAP_ADDR_BITS = 20;
    localparam int FREE_ENTRIES   = 32;
    localparam int ALLOC_ENTRIES  = 64;
    localparam int GRANULE        = 8;

    // Fixed field widths
    localparam int ADDR_W = 48;
    localparam int REQ_W  = 21;
    localparam int STAT_W = 3;

    localparam int S_TDATA_W = ((REQ_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDR_W + STAT_W + 7) / 8) * 8;

    // Derived widths
    localparam int OFF_W  = HEAP_ADDR_BITS + 1;
    localparam int NEED_W = REQ_W + 1;
    localparam int CMP_W  = (OFF_W > NEED_W) ? OFF_W : NEED_W;
    localparam int FIDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int FCNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int RIDX_W = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
    localparam int RCNT_W = $clog2(ALLOC_ENTRIES + 1);

    // Allocation constants
    localparam int HDR_BYTES = 16;
    localparam int MIN_SPLIT = 24;
    localparam int MIN_HEAP  = 32;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOP     = 3'd1,
        ST_OOM     = 3'd2,
        ST_FULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT,
        S_SLOT,
        S_SPLIT,
        S_DEL,
        S_REC_RD,
        S_REC_CHK,
        S_POS,
        S_MERGE,
        S_INS,
        S_DONE
    } fsm_t;

endpackage

// File: design/first_fit_heap_allocator_core.sv
// First-fit heap allocator. One request beat (s_tuser: 0 allocate, 1 free)
// gives one result beat. A request is worked on alone by a sequencer that
// steps one free-table entry or one allocation record at a time through a
// single read port on each table. Allocate: scan the extents for the first
// that fits, scan the records up to the first unused one, and when an extent
// is consumed whole, move each extent above it down. Free: check the valid
// records for the block, walk the extents below it, then merge or insert,
// moving extents on an insert or a double merge. A heap size write clears
// all records and sets the free table to one extent over the whole heap at
// once; configuration is to be written only while no request is open, which
// the core itself does not enforce.
module first_fit_heap_allocator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,  // request_size[20:0], block_address[68:21]
    input  logic                            s_tuser,  // operation
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata,  // granted_address[47:0], status[50:48]
    // configuration
    input  logic                            cfg_wen,
    input  logic                            cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]     cfg_wdata
);

    localparam int OW = ffha_pkg::OFF_W;
    localparam int CW = ffha_pkg::CMP_W;
    localparam int AW = ffha_pkg::ADDR_W;
    localparam int FW = ffha_pkg::FIDX_W;
    localparam int FC = ffha_pkg::FCNT_W;
    localparam int RW = ffha_pkg::RIDX_W;
    localparam int RC = ffha_pkg::RCNT_W;
    localparam int NW = ffha_pkg::NEED_W;
    localparam int M_TDATA_W_PAD = ffha_pkg::M_TDATA_W;

    localparam logic [CW-1:0] HEAP_MAX  = CW'(1) << ffha_pkg::HEAP_ADDR_BITS;
    localparam logic [CW-1:0] HEAP_MIN  = CW'(ffha_pkg::MIN_HEAP);
    localparam logic [CW-1:0] SPLIT_MIN = CW'(ffha_pkg::MIN_SPLIT);
    localparam logic [AW-1:0] HDR       = AW'(ffha_pkg::HDR_BYTES);
    localparam logic [NW-1:0] RND       = NW'(ffha_pkg::HDR_BYTES + ffha_pkg::GRANULE - 1);

    // free table and allocation records
    logic [OW-1:0] fx_off_reg [ffha_pkg::FREE_ENTRIES];
    logic [OW-1:0] fx_len_reg [ffha_pkg::FREE_ENTRIES];
    logic [2*OW-1:0] rec_mem [ffha_pkg::ALLOC_ENTRIES];
    logic [2*OW-1:0] rec_q_reg;
    logic [ffha_pkg::ALLOC_ENTRIES-1:0] valid_reg;

    // control and work registers
    ffha_pkg::fsm_t    state_reg, state_next;
    ffha_pkg::status_t stat_reg, stat_next;
    logic [AW-1:0] grant_reg, grant_next;
    logic [AW-1:0] faddr_reg, faddr_next;
    logic [NW-1:0] need_reg, need_next;
    logic [FC-1:0] idx_reg, idx_next;
    logic [FC-1:0] pos_reg, pos_next;
    logic [FC-1:0] cnt_reg, cnt_next;
    logic [RC-1:0] slot_reg, slot_next;
    logic [OW-1:0] off_reg, off_next;
    logic [OW-1:0] len_reg, len_next;
    logic [OW-1:0] prev_off_reg, prev_off_next;
    logic [OW-1:0] prev_len_reg, prev_len_next;
    logic [AW-1:0] base_reg;
    logic          m_valid_reg, m_valid_next;
    logic [AW-1:0] m_addr_reg, m_addr_next;
    logic [ffha_pkg::STAT_W-1:0] m_stat_reg, m_stat_next;

    // table port controls
    logic [FW-1:0] rd_idx;
    logic [OW-1:0] rd_off, rd_len;
    logic          fx_we;
    logic [FW-1:0] fx_widx;
    logic [OW-1:0] fx_woff, fx_wlen;
    logic          rec_we, val_set, val_clr;
    logic [RW-1:0] slot_idx;

    // shared arithmetic
    logic [CW-1:0] len_w, need_w, rem_w;
    logic [AW-1:0] rec_addr;
    logic          up, down;
    logic          accept;
    logic [CW-1:0] cfg_size_w, cfg_size_sat;

    assign slot_idx = slot_reg[RW-1:0];
    assign rd_off   = fx_off_reg[rd_idx];
    assign rd_len   = fx_len_reg[rd_idx];
    assign len_w    = CW'(rd_len);
    assign need_w   = CW'(need_reg);
    assign rem_w    = len_w - need_w;
    assign rec_addr = base_reg + AW'(rec_q_reg[2*OW-1:OW]) + HDR;
    assign up   = (pos_reg < cnt_reg) && ((off_reg + len_reg) == rd_off);
    assign down = (pos_reg != '0) && ((prev_off_reg + prev_len_reg) == off_reg);

    assign s_tready = (state_reg == ffha_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W_PAD'({m_stat_reg, m_addr_reg});

    // saturate a heap size write
    assign cfg_size_w   = CW'(cfg_wdata[ffha_pkg::REQ_W-1:0]);
    assign cfg_size_sat = (cfg_size_w < HEAP_MIN) ? HEAP_MIN :
                          (cfg_size_w > HEAP_MAX) ? HEAP_MAX : cfg_size_w;

    // sequencer: next state, work registers and table writes
    always_comb begin
        state_next    = state_reg;
        stat_next     = stat_reg;
        grant_next    = grant_reg;
        faddr_next    = faddr_reg;
        need_next     = need_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        prev_off_next = prev_off_reg;
        prev_len_next = prev_len_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_stat_next   = m_stat_reg;
        rd_idx        = idx_reg[FW-1:0];
        fx_we         = 1'b0;
        fx_widx       = idx_reg[FW-1:0];
        fx_woff       = rd_off;
        fx_wlen       = rd_len;
        rec_we        = 1'b0;
        val_set       = 1'b0;
        val_clr       = 1'b0;

        // drop the result beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ffha_pkg::S_IDLE: begin
                if (accept) begin
                    grant_next = '0;
                    idx_next   = '0;
                    slot_next  = '0;
                    faddr_next = s_tdata[ffha_pkg::REQ_W +: AW];
                    need_next  = (NW'(s_tdata[ffha_pkg::REQ_W-1:0]) + RND)
                                 & ~NW'(ffha_pkg::GRANULE - 1);
                    if (s_tuser == ffha_pkg::OP_ALLOC) begin
                        if (s_tdata[ffha_pkg::REQ_W-1:0] == '0) begin
                            stat_next  = ffha_pkg::ST_NOP;
                            state_next = ffha_pkg::S_DONE;
                        end else begin
                            state_next = ffha_pkg::S_FIT;
                        end
                    end else begin
                        if (s_tdata[ffha_pkg::REQ_W +: AW] == '0) begin
                            stat_next  = ffha_pkg::ST_NOP;
                            state_next = ffha_pkg::S_DONE;
                        end else begin
                            state_next = ffha_pkg::S_REC_RD;
                        end
                    end
                end
            end

            // walk extents for the first that fits
            ffha_pkg::S_FIT: begin
                if (idx_reg >= cnt_reg) begin
                    stat_next  = ffha_pkg::ST_OOM;
                    state_next = ffha_pkg::S_DONE;
                end else if (len_w >= need_w) begin
                    pos_next   = idx_reg;
                    state_next = ffha_pkg::S_SLOT;
                end else begin
                    idx_next = idx_reg + FC'(1);
                end
            end

            // walk records for an unused slot
            ffha_pkg::S_SLOT: begin
                if (slot_reg == RC'(ffha_pkg::ALLOC_ENTRIES)) begin
                    stat_next  = ffha_pkg::ST_FULL;
                    state_next = ffha_pkg::S_DONE;
                end else if (!valid_reg[slot_idx]) begin
                    state_next = ffha_pkg::S_SPLIT;
                end else begin
                    slot_next = slot_reg + RC'(1);
                end
            end

            // carve the block out of the chosen extent
            ffha_pkg::S_SPLIT: begin
                rd_idx     = pos_reg[FW-1:0];
                rec_we     = 1'b1;
                val_set    = 1'b1;
                off_next   = rd_off;
                grant_next = base_reg + AW'(rd_off) + HDR;
                stat_next  = ffha_pkg::ST_OK;
                if (rem_w >= SPLIT_MIN) begin
                    len_next   = OW'(need_reg);
                    fx_we      = 1'b1;
                    fx_widx    = pos_reg[FW-1:0];
                    fx_woff    = rd_off + OW'(need_reg);
                    fx_wlen    = OW'(rem_w);
                    state_next = ffha_pkg::S_DONE;
                end else begin
                    len_next   = rd_len;
                    idx_next   = pos_reg;
                    state_next = ffha_pkg::S_DEL;
                end
            end

            // close the gap left by a removed extent
            ffha_pkg::S_DEL: begin
                rd_idx = FW'(idx_reg + FC'(1));
                if ((idx_reg + FC'(1)) < cnt_reg) begin
                    fx_we    = 1'b1;
                    fx_widx  = idx_reg[FW-1:0];
                    idx_next = idx_reg + FC'(1);
                end else begin
                    cnt_next   = cnt_reg - FC'(1);
                    state_next = ffha_pkg::S_DONE;
                end
            end

            // walk records for the freed address
            ffha_pkg::S_REC_RD: begin
                if (slot_reg == RC'(ffha_pkg::ALLOC_ENTRIES)) begin
                    stat_next  = ffha_pkg::ST_UNKNOWN;
                    state_next = ffha_pkg::S_DONE;
                end else if (valid_reg[slot_idx]) begin
                    state_next = ffha_pkg::S_REC_CHK;
                end else begin
                    slot_next = slot_reg + RC'(1);
                end
            end

            ffha_pkg::S_REC_CHK: begin
                if (rec_addr == faddr_reg) begin
                    off_next   = rec_q_reg[2*OW-1:OW];
                    len_next   = rec_q_reg[OW-1:0];
                    idx_next   = '0;
                    state_next = ffha_pkg::S_POS;
                end else begin
                    slot_next  = slot_reg + RC'(1);
                    state_next = ffha_pkg::S_REC_RD;
                end
            end

            // find the first extent above the freed block
            ffha_pkg::S_POS: begin
                if ((idx_reg < cnt_reg) && (rd_off <= off_reg)) begin
                    prev_off_next = rd_off;
                    prev_len_next = rd_len;
                    idx_next      = idx_reg + FC'(1);
                end else begin
                    pos_next   = idx_reg;
                    state_next = ffha_pkg::S_MERGE;
                end
            end

            // merge with neighbors or open a new extent
            ffha_pkg::S_MERGE: begin
                rd_idx    = pos_reg[FW-1:0];
                stat_next = ffha_pkg::ST_OK;
                fx_woff   = prev_off_reg;
                fx_widx   = FW'(pos_reg - FC'(1));
                if (up && down) begin
                    fx_we      = 1'b1;
                    fx_wlen    = prev_len_reg + len_reg + rd_len;
                    val_clr    = 1'b1;
                    idx_next   = pos_reg;
                    state_next = ffha_pkg::S_DEL;
                end else if (down) begin
                    fx_we      = 1'b1;
                    fx_wlen    = prev_len_reg + len_reg;
                    val_clr    = 1'b1;
                    state_next = ffha_pkg::S_DONE;
                end else if (up) begin
                    fx_we      = 1'b1;
                    fx_widx    = pos_reg[FW-1:0];
                    fx_woff    = off_reg;
                    fx_wlen    = len_reg + rd_len;
                    val_clr    = 1'b1;
                    state_next = ffha_pkg::S_DONE;
                end else if (cnt_reg == FC'(ffha_pkg::FREE_ENTRIES)) begin
                    stat_next  = ffha_pkg::ST_FULL;
                    state_next = ffha_pkg::S_DONE;
                end else begin
                    val_clr    = 1'b1;
                    idx_next   = cnt_reg;
                    state_next = ffha_pkg::S_INS;
                end
            end

            // open a hole at the insert position
            ffha_pkg::S_INS: begin
                rd_idx = FW'(idx_reg - FC'(1));
                fx_we  = 1'b1;
                if (idx_reg > pos_reg) begin
                    fx_widx  = idx_reg[FW-1:0];
                    idx_next = idx_reg - FC'(1);
                end else begin
                    fx_widx    = pos_reg[FW-1:0];
                    fx_woff    = off_reg;
                    fx_wlen    = len_reg;
                    cnt_next   = cnt_reg + FC'(1);
                    state_next = ffha_pkg::S_DONE;
                end
            end

            // hand the result to the output register
            ffha_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = (stat_reg == ffha_pkg::ST_OK) ? grant_reg : '0;
                    m_stat_next  = stat_reg;
                    state_next   = ffha_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase

        // a heap size write resets the free table
        if (cfg_wen && (cfg_index == ffha_pkg::CFG_HEAP_SIZE)) begin
            cnt_next = FC'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffha_pkg::S_IDLE;
            cnt_reg     <= FC'(1);
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            base_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (val_set) begin
                valid_reg[slot_idx] <= 1'b1;
            end
            if (val_clr) begin
                valid_reg[slot_idx] <= 1'b0;
            end
            if (cfg_wen && (cfg_index == ffha_pkg::CFG_HEAP_BASE)) begin
                base_reg <= cfg_wdata;
            end
            if (cfg_wen && (cfg_index == ffha_pkg::CFG_HEAP_SIZE)) begin
                valid_reg <= '0;
            end
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        stat_reg     <= stat_next;
        grant_reg    <= grant_next;
        faddr_reg    <= faddr_next;
        need_reg     <= need_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        slot_reg     <= slot_next;
        off_reg      <= off_next;
        len_reg      <= len_next;
        prev_off_reg <= prev_off_next;
        prev_len_reg <= prev_len_next;
        m_addr_reg   <= m_addr_next;
        m_stat_reg   <= m_stat_next;
    end

    // free table writes; entry 0 takes the whole heap after reset or resize
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fx_off_reg[0] <= '0;
            fx_len_reg[0] <= OW'(HEAP_MAX);
        end else if (cfg_wen && (cfg_index == ffha_pkg::CFG_HEAP_SIZE)) begin
            fx_off_reg[0] <= '0;
            fx_len_reg[0] <= OW'(cfg_size_sat);
        end else if (fx_we) begin
            fx_off_reg[fx_widx] <= fx_woff;
            fx_len_reg[fx_widx] <= fx_wlen;
        end
    end

    // record memory, registered read
    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[slot_idx] <= {off_next, len_next};
        end
        rec_q_reg <= rec_mem[slot_idx];
    end

endmodule

// File: design/ffha_checker.sv
module ffha_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata
);

    // no second request beat right behind the first
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is open");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // status stays within its codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50:48] == ffha_pkg::ST_OK) ||
                     (m_tdata[50:48] == ffha_pkg::ST_NOP) ||
                     (m_tdata[50:48] == ffha_pkg::ST_OOM) ||
                     (m_tdata[50:48] == ffha_pkg::ST_FULL) ||
                     (m_tdata[50:48] == ffha_pkg::ST_UNKNOWN))
        else $error("bad status code");

    // a failed request grants nothing
    a_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[50:48] != ffha_pkg::ST_OK) |-> (m_tdata[47:0] == '0))
        else $error("address given with error status");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
